// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the circular deque
// Command and result structs, the action codes and the cell control group.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 4;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef struct packed {
        action_t                    action;
        logic signed [DATA_W-1:0]   data_value;
    } cmd_t;

    typedef struct packed {
        logic                       accepted;
        logic [COUNT_W-1:0]         element_count;
        logic signed [DATA_W-1:0]   front_value;
        logic signed [DATA_W-1:0]   back_value;
    } result_t;

    // Per-cycle command to every cell of one chain.
    // shift_in / shift_out act at the end the chain is anchored to,
    // append / remove act at its far (open) end.
    typedef struct packed {
        logic shift_in;
        logic shift_out;
        logic append;
        logic remove;
    } cdq_ctrl_t;

endpackage

// ===== sv/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of a deque chain
// Holds one element and its valid bit; takes data from either neighbor on a
// shift, or the pushed value when it is the first free cell.
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdq_pkg::cdq_ctrl_t                  ctrl,
    input  logic signed [cdq_pkg::DATA_W-1:0]   value,
    input  logic signed [cdq_pkg::DATA_W-1:0]   prev_data,
    input  logic                                prev_valid,
    input  logic signed [cdq_pkg::DATA_W-1:0]   next_data,
    input  logic                                next_valid,
    output logic signed [cdq_pkg::DATA_W-1:0]   data,
    output logic                                valid
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     valid_reg;
    logic                     valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.shift_in)
        begin
            data_next  = prev_data;
            valid_next = prev_valid;
        end
        else if (ctrl.shift_out)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (ctrl.append && prev_valid && !valid_reg)
        begin
            // first free cell takes the pushed value
            data_next  = value;
            valid_next = 1'b1;
        end
        else if (ctrl.remove && valid_reg && !next_valid)
        begin
            // last occupied cell drops out
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ===== sv/cdq_chain.sv =====
// ----------------------------------------------------------------------------
// cdq_chain: row of cells anchored at one end of the deque
// Cell 0 always holds the element at the anchored end; occupied cells form
// a contiguous run starting at cell 0.
// ----------------------------------------------------------------------------
module cdq_chain #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdq_pkg::cdq_ctrl_t                  ctrl,
    input  logic signed [cdq_pkg::DATA_W-1:0]   value,
    output logic signed [cdq_pkg::DATA_W-1:0]   end_data,
    output logic                                end_valid
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] cell_data  [DEPTH];
    logic                     cell_valid [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] prev_data;
            logic                     prev_valid;
            logic signed [DATA_W-1:0] next_data;
            logic                     next_valid;

            // the anchored end sees the new value as an always-valid neighbor
            if (i == 0)
            begin : g_first
                assign prev_data  = value;
                assign prev_valid = 1'b1;
            end
            else
            begin : g_mid_prev
                assign prev_data  = cell_data[i-1];
                assign prev_valid = cell_valid[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_data  = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_mid_next
                assign next_data  = cell_data[i+1];
                assign next_valid = cell_valid[i+1];
            end

            cdq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .value      (value),
                .prev_data  (prev_data),
                .prev_valid (prev_valid),
                .next_data  (next_data),
                .next_valid (next_valid),
                .data       (cell_data[i]),
                .valid      (cell_valid[i])
            );
        end
    endgenerate

    assign end_data  = cell_data[0];
    assign end_valid = cell_valid[0];

endmodule

// ===== sv/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: fixed-capacity double-ended queue
// Push or pop at either end; reports count and both end values per command.
// ----------------------------------------------------------------------------
// Usage:
//   A command (cmd.action, cmd.data_value) transfers at a rising edge where
//   start is high and busy is low. busy stays low: every cell updates in the
//   same edge, so a command can be issued every cycle.
//   Each command gives one result, shown on result for exactly one cycle
//   with done high, the cycle after the command transfer. The receiver
//   cannot stall; a result not
//   taken in its cycle is gone.
//   Storage is two rows of DEPTH cells, one anchored at the front and one at
//   the back, so both end values come from a fixed cell. The row length
//   sets the capacity; each cell talks only to its two neighbors.
//   Push on full and pop on empty report accepted = 0 and change nothing.
//   Reset clears all valid bits and the count: the deque starts empty and
//   done is low. element_count is the count truncated to 4 bits.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cdq_pkg::cmd_t       cmd,
    output logic                done,
    output cdq_pkg::result_t    result
);
    import cdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               done_reg;
    logic               accepted_reg;
    logic               accepted_next;
    logic               take;
    logic               full;
    logic               empty;
    cdq_ctrl_t          front_ctrl;
    cdq_ctrl_t          back_ctrl;
    logic signed [DATA_W-1:0] front_data;
    logic                     front_valid;
    logic signed [DATA_W-1:0] back_data;
    logic                     back_valid;
    logic [31:0]              count_ext;

    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        accepted_next = 1'b0;
        count_next    = count_reg;
        front_ctrl    = '0;
        back_ctrl     = '0;
        if (take)
        begin
            case (cmd.action)
                ACT_PUSH_FRONT:
                begin
                    accepted_next        = !full;
                    front_ctrl.shift_in  = !full;
                    back_ctrl.append     = !full;
                end
                ACT_PUSH_BACK:
                begin
                    accepted_next        = !full;
                    front_ctrl.append    = !full;
                    back_ctrl.shift_in   = !full;
                end
                ACT_POP_FRONT:
                begin
                    accepted_next        = !empty;
                    front_ctrl.shift_out = !empty;
                    back_ctrl.remove     = !empty;
                end
                ACT_POP_BACK:
                begin
                    accepted_next        = !empty;
                    front_ctrl.remove    = !empty;
                    back_ctrl.shift_out  = !empty;
                end
                default:
                begin
                    accepted_next = 1'b0;
                end
            endcase
            if (accepted_next)
            begin
                if (cmd.action inside {ACT_PUSH_FRONT, ACT_PUSH_BACK})
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            done_reg     <= take;
            accepted_reg <= accepted_next;
        end
    end

    cdq_chain #(
        .DEPTH (DEPTH)
    ) u_front_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (front_ctrl),
        .value     (cmd.data_value),
        .end_data  (front_data),
        .end_valid (front_valid)
    );

    cdq_chain #(
        .DEPTH (DEPTH)
    ) u_back_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (back_ctrl),
        .value     (cmd.data_value),
        .end_data  (back_data),
        .end_valid (back_valid)
    );

    assign count_ext = 32'(count_reg);

    assign done                 = done_reg;
    assign result.accepted      = accepted_reg;
    assign result.element_count = count_ext[COUNT_W-1:0];
    assign result.front_value   = front_valid ? front_data : '0;
    assign result.back_value    = back_valid ? back_data : '0;

endmodule

// ===== verif/deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker: scoreboard for the circular deque
// Watches the command and result channels, keeps its own ring of slots,
// predicts each result and compares it field by field, in order.
// ----------------------------------------------------------------------------
module deque_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  cdq_pkg::cmd_t       cmd,
    input  logic                done,
    input  cdq_pkg::result_t    result,
    output int                  fail_count,
    output int                  pending,
    output int                  n_results,
    output int                  n_full_drops,
    output int                  n_empty_pops
);
    import cdq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int IDX_W = $clog2(DEPTH);

    logic signed [DATA_W-1:0] ring_slots [DEPTH];
    logic [IDX_W-1:0]         front_idx;
    logic [IDX_W-1:0]         back_idx;
    logic                     deque_empty;

    result_t expected_results [$];

    function automatic int fill_level();
        if (deque_empty)
            return 0;
        return ((int'(back_idx) + DEPTH - int'(front_idx)) % DEPTH) + 1;
    endfunction

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return IDX_W'((int'(i) + 1) % DEPTH);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return IDX_W'((int'(i) + DEPTH - 1) % DEPTH);
    endfunction

    // Applies one command to the local deque and returns the result it gives.
    function automatic result_t apply_deque_op(input cmd_t c);
        result_t r;
        logic    ok;
        logic    is_push;
        ok      = 1'b0;
        is_push = (c.action == ACT_PUSH_FRONT) || (c.action == ACT_PUSH_BACK);
        if (is_push)
        begin
            if (deque_empty)
            begin
                // first element always lands in slot zero, whichever end
                front_idx     = '0;
                back_idx      = '0;
                ring_slots[0] = c.data_value;
                deque_empty   = 1'b0;
                ok            = 1'b1;
            end
            else if (fill_level() < DEPTH)
            begin
                if (c.action == ACT_PUSH_FRONT)
                begin
                    front_idx             = step_down(front_idx);
                    ring_slots[front_idx] = c.data_value;
                end
                else
                begin
                    back_idx             = step_up(back_idx);
                    ring_slots[back_idx] = c.data_value;
                end
                ok = 1'b1;
            end
            else
            begin
                n_full_drops++;
            end
        end
        else
        begin
            if (!deque_empty)
            begin
                if (front_idx == back_idx)
                begin
                    deque_empty = 1'b1;
                    front_idx   = '0;
                    back_idx    = '0;
                end
                else if (c.action == ACT_POP_FRONT)
                begin
                    front_idx = step_up(front_idx);
                end
                else
                begin
                    back_idx = step_down(back_idx);
                end
                ok = 1'b1;
            end
            else
            begin
                n_empty_pops++;
            end
        end
        r.accepted      = ok;
        r.element_count = COUNT_W'(fill_level());
        r.front_value   = deque_empty ? '0 : ring_slots[front_idx];
        r.back_value    = deque_empty ? '0 : ring_slots[back_idx];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    bad;
        if (!rst_n)
        begin
            foreach (ring_slots[i])
                ring_slots[i] = '0;
            front_idx   = '0;
            back_idx    = '0;
            deque_empty = 1'b1;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // result of the previous transfer is checked before the new one is queued
            if (done)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $display("%t: unexpected result %h, nothing outstanding", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    if (result.accepted !== want.accepted)
                    begin
                        $display("%t: accepted: expected %0d, got %0d",
                                 $time, want.accepted, result.accepted);
                        bad = 1'b1;
                    end
                    if (result.element_count !== want.element_count)
                    begin
                        $display("%t: element_count: expected %0d, got %0d",
                                 $time, want.element_count, result.element_count);
                        bad = 1'b1;
                    end
                    if (result.front_value !== want.front_value)
                    begin
                        $display("%t: front_value: expected %0d, got %0d",
                                 $time, want.front_value, result.front_value);
                        bad = 1'b1;
                    end
                    if (result.back_value !== want.back_value)
                    begin
                        $display("%t: back_value: expected %0d, got %0d",
                                 $time, want.back_value, result.back_value);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count++;
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_deque_op(cmd));
            pending <= expected_results.size();
        end
    end

endmodule

// ===== verif/circular_deque_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_test: top of the circular deque testbench
// Directed corner commands, then random runs biased toward filling or
// draining (or even) so the deque hits full and empty often; random idle gaps.
// ----------------------------------------------------------------------------
module circular_deque_test;
    import cdq_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    int fail_count;
    int pending;
    int n_results;
    int n_full_drops;
    int n_empty_pops;
    int cycle_count;

    always #6 clk = ~clk;

    circular_deque i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    deque_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .n_results    (n_results),
        .n_full_drops (n_full_drops),
        .n_empty_pops (n_empty_pops)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    function automatic action_t pick_action(input mix_t mix);
        int   push_pct;
        logic at_front;
        push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
        at_front = 1'($urandom_range(1));
        if ($urandom_range(99) < push_pct)
            return at_front ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        return at_front ? ACT_POP_FRONT : ACT_POP_BACK;
    endfunction

    // One command transfer; start stays high into the next call when gap is 0.
    task automatic send_cmd(input action_t act, input logic signed [DATA_W-1:0] val,
                            input int gap);
        cmd_t next_cmd;
        cmd_t junk;
        next_cmd.action     = act;
        next_cmd.data_value = val;
        start <= 1'b1;
        cmd   <= next_cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            junk.action     = action_t'($urandom_range(3));
            junk.data_value = $urandom();
            start <= 1'b0;
            cmd   <= junk;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int   sent;
        int   seg_len;
        mix_t mix;
        logic quiet;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pops, first push via each end, removal of the only element
        send_cmd(ACT_POP_FRONT, VAL_MAX, pick_gap());
        send_cmd(ACT_POP_BACK, VAL_MIN, pick_gap());
        send_cmd(ACT_PUSH_FRONT, VAL_MAX, 0);
        send_cmd(ACT_POP_BACK, '0, 0);
        send_cmd(ACT_PUSH_BACK, VAL_MIN, pick_gap());
        send_cmd(ACT_POP_FRONT, -1, 0);
        // fill to capacity from both ends, wrapping the front index
        for (int i = 0; i < DEPTH_DEF; i++)
            send_cmd((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                     (i % 2) ? VAL_MIN + i : VAL_MAX - i, pick_gap());
        send_cmd(ACT_PUSH_FRONT, -1, 0);
        send_cmd(ACT_PUSH_BACK, '0, 0);
        // drain down to one element, then pop it and pop once more on empty
        for (int i = 0; i < DEPTH_DEF - 1; i++)
            send_cmd((i % 2) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom(), pick_gap());
        send_cmd(ACT_POP_FRONT, '0, 0);
        send_cmd(ACT_POP_BACK, '0, pick_gap());

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mix     = mix_t'($urandom_range(2));
            quiet   = ($urandom_range(3) == 0);
            seg_len = $urandom_range(8, 30);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++)
            begin
                send_cmd(pick_action(mix), pick_value(), quiet ? 0 : pick_gap());
                sent++;
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands: %0d pushes dropped on a full deque, %0d pops on empty",
                 n_results, n_full_drops, n_empty_pops);
        $display("both ends exercised, with wraparound and random idle gaps");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
